@@ src/vole_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vole machine package
// Shared types, codes and sizes of the Vole machine step block.
// ----------------------------------------------------------------------------
package vole_pkg;

    localparam int MemBytes = 256;
    localparam int NumRegs  = 16;

    typedef enum logic [2:0] {
        KIND_RESTART = 3'd0,
        KIND_WRITE   = 3'd1,
        KIND_STEP    = 3'd2,
        KIND_READMEM = 3'd3,
        KIND_READREG = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HALT    = 2'd1,
        ST_HALTED  = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'h1,
        OP_LDI   = 4'h2,
        OP_STORE = 4'h3,
        OP_MOVE  = 4'h4,
        OP_ADD   = 4'h5,
        OP_OR    = 4'h7,
        OP_AND   = 4'h8,
        OP_XOR   = 4'h9,
        OP_ROT   = 4'hA,
        OP_JMP   = 4'hB,
        OP_HALT  = 4'hC
    } opcode_t;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FETCH2, S_EXEC, S_DATA, S_RDMEM
    } bstate_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] address;
        logic [7:0] data;
        logic [3:0] reg_index;
    } item_t;

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] d;
        begin
            d = {v, v} >> n;
            return d[7:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ src/vole_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vole front end
// Accept request words into a two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
module vole_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire vole_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output vole_pkg::item_t     q_item
);
    import vole_pkg::*;

    item_t      slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, wr_ptr_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue overflow");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push)
        else $error("push into full queue");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1))
        else $error("queue count jump");

endmodule
`default_nettype wire

@@ src/vole_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vole execution unit
// Carry out each request against memory and registers; clear memory by sweep.
// ----------------------------------------------------------------------------
module vole_back #(
    parameter int MEM_BYTES = vole_pkg::MemBytes,
    parameter int NUM_REGS  = vole_pkg::NumRegs
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire vole_pkg::item_t q_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           status,
    output logic [8:0]           pc_value,
    output logic [15:0]          fetched_word,
    output logic [15:0]          executed_total,
    output logic [7:0]           read_value
);
    import vole_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = $clog2(NUM_REGS);

    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    regs_reg [NUM_REGS];
    logic [NUM_REGS-1:0] rvalid_reg;

    bstate_t       state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [8:0]    pc_reg;
    logic          halt_reg;
    logic [15:0]   cnt_reg;
    logic [7:0]    hi_reg, mrd_reg;
    logic [7:0]    raddr;
    logic          mwe;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    logic          ov_reg;
    logic [1:0]    o_st_reg;
    logic [15:0]   o_word_reg;
    logic [7:0]    o_rd_reg;

    logic [15:0]   word;
    logic [3:0]    op, r, s, t;
    logic [7:0]    rv, sv, tv, r0v;
    logic          finish;
    logic          out_free;

    function automatic logic [7:0] rdreg(input logic [RW-1:0] i);
        begin
            return rvalid_reg[i] ? regs_reg[i] : 8'd0;
        end
    endfunction

    assign word = {hi_reg, mrd_reg};
    assign op = word[15:12];
    assign r  = word[11:8];
    assign s  = word[7:4];
    assign t  = word[3:0];
    assign rv = rdreg(r[RW-1:0]);
    assign sv = rdreg(s[RW-1:0]);
    assign tv = rdreg(t[RW-1:0]);
    assign r0v = rdreg('0);

    assign out_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign status = o_st_reg;
    assign pc_value = pc_reg;
    assign fetched_word = o_word_reg;
    assign executed_total = cnt_reg;
    assign read_value = o_rd_reg;

    always_comb
    begin
        state_next = state_reg;
        q_ready = 1'b0;
        raddr = pc_reg[7:0];
        mwe = 1'b0;
        waddr = q_item.address[AW-1:0];
        wdata = q_item.data;
        finish = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mwe = 1'b1;
                waddr = clr_reg;
                wdata = 8'd0;
                if (clr_reg == AW'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    case (q_item.kind)
                        KIND_RESTART:
                        begin
                            q_ready = 1'b1;
                            state_next = S_CLEAR;
                            finish = 1'b1;
                        end
                        KIND_WRITE:
                        begin
                            q_ready = 1'b1;
                            mwe = 1'b1;
                            finish = 1'b1;
                        end
                        KIND_STEP:
                        begin
                            q_ready = 1'b1;
                            finish = halt_reg || (pc_reg >= 9'd255);
                            if (!finish)
                            begin
                                state_next = S_FETCH2;
                            end
                        end
                        KIND_READMEM:
                        begin
                            q_ready = 1'b1;
                            raddr = q_item.address;
                            state_next = S_RDMEM;
                        end
                        default:
                        begin
                            q_ready = 1'b1;
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH2:
            begin
                raddr = pc_reg[7:0] + 8'd1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (op == OP_LOAD)
                begin
                    raddr = word[7:0];
                    state_next = S_DATA;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                    if (op == OP_STORE)
                    begin
                        mwe = 1'b1;
                        waddr = word[AW-1:0];
                        wdata = rv;
                    end
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDMEM:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mem[waddr] <= wdata;
        end
        mrd_reg <= mem[raddr[AW-1:0]];
        if (state_reg == S_FETCH2)
        begin
            hi_reg <= mrd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= 9'd0;
            halt_reg   <= 1'b0;
            cnt_reg    <= 16'd0;
            rvalid_reg <= '0;
            ov_reg     <= 1'b0;
            o_st_reg   <= ST_OK;
            o_word_reg <= 16'd0;
            o_rd_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_IDLE && q_ready)
            begin
                o_word_reg <= 16'd0;
                o_rd_reg   <= 8'd0;
                o_st_reg   <= ST_OK;
                case (q_item.kind)
                    KIND_RESTART:
                    begin
                        clr_reg    <= '0;
                        pc_reg     <= {1'b0, q_item.address};
                        halt_reg   <= 1'b0;
                        cnt_reg    <= 16'd0;
                        rvalid_reg <= '0;
                    end
                    KIND_STEP:
                    begin
                        if (halt_reg)
                        begin
                            o_st_reg <= ST_HALTED;
                        end
                        else if (pc_reg >= 9'd255)
                        begin
                            o_st_reg <= ST_RANGE;
                        end
                    end
                    KIND_READREG:
                    begin
                        o_rd_reg <= rdreg(q_item.reg_index[RW-1:0]);
                    end
                    default:
                    begin
                    end
                endcase
                if (finish)
                begin
                    ov_reg <= 1'b1;
                end
            end
            if (state_reg == S_RDMEM && out_free)
            begin
                o_rd_reg <= mrd_reg;
                ov_reg   <= 1'b1;
            end
            if (state_reg == S_DATA && out_free)
            begin
                regs_reg[r[RW-1:0]]   <= mrd_reg;
                rvalid_reg[r[RW-1:0]] <= 1'b1;
                o_word_reg <= {hi_reg, 8'd0} | 16'(o_word_reg[7:0]);
                ov_reg     <= 1'b1;
            end
            if (state_reg == S_EXEC && (op == OP_LOAD || out_free))
            begin
                o_word_reg <= word;
                o_st_reg   <= ST_OK;
                pc_reg <= pc_reg + 9'd2;
                if (cnt_reg != 16'hFFFF)
                begin
                    cnt_reg <= cnt_reg + 16'd1;
                end
                if (op != OP_LOAD)
                begin
                    ov_reg <= 1'b1;
                end
                case (op)
                    OP_LDI:
                    begin
                        regs_reg[r[RW-1:0]] <= word[7:0];
                        rvalid_reg[r[RW-1:0]] <= 1'b1;
                    end
                    OP_MOVE:
                    begin
                        regs_reg[t[RW-1:0]] <= sv;
                        rvalid_reg[t[RW-1:0]] <= 1'b1;
                    end
                    OP_ADD:
                    begin
                        regs_reg[r[RW-1:0]] <= sv + tv;
                        rvalid_reg[r[RW-1:0]] <= 1'b1;
                    end
                    OP_OR:
                    begin
                        regs_reg[r[RW-1:0]] <= sv | tv;
                        rvalid_reg[r[RW-1:0]] <= 1'b1;
                    end
                    OP_AND:
                    begin
                        regs_reg[r[RW-1:0]] <= sv & tv;
                        rvalid_reg[r[RW-1:0]] <= 1'b1;
                    end
                    OP_XOR:
                    begin
                        regs_reg[r[RW-1:0]] <= sv ^ tv;
                        rvalid_reg[r[RW-1:0]] <= 1'b1;
                    end
                    OP_ROT:
                    begin
                        regs_reg[r[RW-1:0]] <= rotr8(rv, t[2:0]);
                        rvalid_reg[r[RW-1:0]] <= 1'b1;
                    end
                    OP_JMP:
                    begin
                        if (rv == r0v)
                        begin
                            pc_reg <= {1'b0, word[7:0]};
                        end
                    end
                    OP_HALT:
                    begin
                        halt_reg <= 1'b1;
                        o_st_reg <= ST_HALT;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_ready)
        else $error("request taken during clear");
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg && !(state_reg == S_IDLE && q_ready)) |=> halt_reg)
        else $error("halt flag dropped");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(o_word_reg) && $stable(o_st_reg)))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

@@ src/vole_machine_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vole machine step
// Teaching machine with 16 byte registers and 256 bytes of memory.
// ----------------------------------------------------------------------------
// One result word per request word. A two-entry queue takes requests while the
// execution unit works. The single memory port reads the two instruction bytes
// of a step one after the other, and a memory load reads its data byte after
// them. After reset and after each restart the memory is cleared by a sweep
// over every byte, during which no request is executed.
module vole_machine_step #(
    parameter int MEM_BYTES = vole_pkg::MemBytes,
    parameter int NUM_REGS  = vole_pkg::NumRegs
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  address,
    input  wire logic [7:0]  data,
    input  wire logic [3:0]  reg_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [8:0]       pc_value,
    output logic [15:0]      fetched_word,
    output logic [15:0]      executed_total,
    output logic [7:0]       read_value
);
    import vole_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item = '{kind: kind, address: address, data: data, reg_index: reg_index};

    vole_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    vole_back #(
        .MEM_BYTES (MEM_BYTES),
        .NUM_REGS  (NUM_REGS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .pc_value       (pc_value),
        .fetched_word   (fetched_word),
        .executed_total (executed_total),
        .read_value     (read_value)
    );

endmodule
`default_nettype wire
